>>> rtl/height_histogram_weighted_mean_assert.svh
// Assertion macros used by the checker file.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef HEIGHT_HISTOGRAM_WEIGHTED_MEAN_ASSERT_SVH
`define HEIGHT_HISTOGRAM_WEIGHTED_MEAN_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define HHWM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hhwm next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define HHWM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hhwm same-cycle check failed");

`endif

>>> rtl/hhwm_pkg.sv
`default_nettype none
package hhwm_pkg;

    localparam int BINS       = 13;
    localparam int MAX_PIXELS = 4096;
    localparam int FRAC_BITS  = 8;

    localparam int HALF     = (BINS - 1) / 2;
    localparam int BIN_W    = $clog2(BINS);
    localparam int CNT_W    = $clog2(MAX_PIXELS + 1);
    localparam int HEIGHT_W = 16;
    localparam int TONE_W   = 16;
    localparam int TIDX_W   = 4;
    localparam int PIX_W    = 13;
    localparam int QUO_W    = TONE_W;
    // sum of count*weight is below MAX_PIXELS * 2^TONE_W
    localparam int SUM_W    = CNT_W + TONE_W;
    localparam int MAG_W    = HEIGHT_W + 2;
    localparam int RND      = (FRAC_BITS == 0) ? 0 : (1 << (FRAC_BITS - 1));
    localparam int STEP_MAX = (BINS > QUO_W) ? BINS : QUO_W;
    localparam int STEP_W   = $clog2(STEP_MAX + 1);

    typedef enum logic [0:0] {
        OP_SAMPLE = 1'b0,
        OP_TONE   = 1'b1
    } opcode_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MAC  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0]  bin_cnt;
        logic [TONE_W-1:0] tone;
        logic [CNT_W-1:0]  frame_cnt;
        logic              dropped;
    } hist_rd_t;

    typedef struct packed {
        logic load_prod;
        logic acc_clr;
        logic acc_add;
        logic div_step;
    } alu_ctl_t;

    // Round half away from zero, clamp to +-HALF, offset to a bin index.
    function automatic logic [BIN_W-1:0] height_to_bin(input logic signed [HEIGHT_W-1:0] h);
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [MAG_W-1:0] r;
        logic [MAG_W-1:0] b;
        neg = h[HEIGHT_W-1];
        mag = neg ? (MAG_W'(0) - MAG_W'(h)) : MAG_W'(h);
        r   = (mag + MAG_W'(RND)) >> FRAC_BITS;
        if (r > MAG_W'(HALF))
        begin
            r = MAG_W'(HALF);
        end
        b = neg ? (MAG_W'(HALF) - r) : (MAG_W'(HALF) + r);
        return b[BIN_W-1:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/hhwm_hist.sv
`default_nettype none
module hhwm_hist (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 sample_en,
    input  wire logic signed [hhwm_pkg::HEIGHT_W-1:0] height,
    input  wire logic                                 tone_we,
    input  wire logic [hhwm_pkg::TIDX_W-1:0]          tone_index,
    input  wire logic [hhwm_pkg::TONE_W-1:0]          tone_weight,
    input  wire logic [hhwm_pkg::BIN_W-1:0]           rd_idx,
    input  wire logic                                 clear,
    output hhwm_pkg::hist_rd_t                        rd
);
    import hhwm_pkg::*;

    logic [CNT_W-1:0]  bin_cnt_reg [BINS];
    logic [CNT_W-1:0]  bin_cnt_next [BINS];
    logic [TONE_W-1:0] tone_reg [BINS];
    logic [TONE_W-1:0] tone_next [BINS];
    logic [CNT_W-1:0]  frame_cnt_reg, frame_cnt_next;
    logic              dropped_reg, dropped_next;
    logic              full;
    logic              count_en;
    logic [BIN_W-1:0]  bin;

    assign full     = (frame_cnt_reg == CNT_W'(MAX_PIXELS));
    assign count_en = sample_en && !full;
    assign bin      = height_to_bin(height);

    always_comb
    begin
        for (int i = 0; i < BINS; i++)
        begin
            bin_cnt_next[i] = bin_cnt_reg[i];
            tone_next[i]    = tone_reg[i];
            if (clear)
            begin
                bin_cnt_next[i] = '0;
            end
            else if (count_en && (bin == BIN_W'(i)))
            begin
                bin_cnt_next[i] = bin_cnt_reg[i] + CNT_W'(1);
            end
            // writes to an index past the last bin fall through
            if (tone_we && (32'(tone_index) == i))
            begin
                tone_next[i] = tone_weight;
            end
        end
    end

    always_comb
    begin
        frame_cnt_next = frame_cnt_reg;
        dropped_next   = dropped_reg;
        if (clear)
        begin
            frame_cnt_next = '0;
            dropped_next   = 1'b0;
        end
        else if (sample_en)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                frame_cnt_next = frame_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BINS; i++)
            begin
                bin_cnt_reg[i] <= '0;
                tone_reg[i]    <= '0;
            end
            frame_cnt_reg <= '0;
            dropped_reg   <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < BINS; i++)
            begin
                bin_cnt_reg[i] <= bin_cnt_next[i];
                tone_reg[i]    <= tone_next[i];
            end
            frame_cnt_reg <= frame_cnt_next;
            dropped_reg   <= dropped_next;
        end
    end

    always_comb
    begin
        rd.bin_cnt   = '0;
        rd.tone      = '0;
        if (32'(rd_idx) < BINS)
        begin
            rd.bin_cnt = bin_cnt_reg[rd_idx];
            rd.tone    = tone_reg[rd_idx];
        end
        rd.frame_cnt = frame_cnt_reg;
        rd.dropped   = dropped_reg;
    end

endmodule
`default_nettype wire

>>> rtl/hhwm_alu.sv
`default_nettype none
module hhwm_alu (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  hhwm_pkg::alu_ctl_t              ctl,
    input  wire logic [hhwm_pkg::CNT_W-1:0] bin_cnt,
    input  wire logic [hhwm_pkg::TONE_W-1:0] tone,
    input  wire logic [hhwm_pkg::CNT_W-1:0] divisor,
    output logic      [hhwm_pkg::QUO_W-1:0] quotient
);
    import hhwm_pkg::*;

    logic [SUM_W-1:0] prod_reg, prod_next;
    logic [SUM_W-1:0] acc_reg, acc_next;
    logic [SUM_W:0]   op_a, op_b, add_res;
    logic             sub;
    logic [CNT_W:0]   rem_shift;
    logic [CNT_W-1:0] rem_new;
    logic             ge;

    assign prod_next = ctl.load_prod ? (SUM_W'(bin_cnt) * SUM_W'(tone)) : prod_reg;

    // acc doubles as {remainder, quotient} during the division; the high
    // part of the sum is already below the divisor, so no prealignment
    assign rem_shift = {acc_reg[SUM_W-1:QUO_W], acc_reg[QUO_W-1]};

    always_comb
    begin
        if (ctl.div_step)
        begin
            op_a = (SUM_W+1)'(rem_shift);
            op_b = (SUM_W+1)'(divisor);
            sub  = 1'b1;
        end
        else
        begin
            op_a = {1'b0, acc_reg};
            op_b = {1'b0, prod_reg};
            sub  = 1'b0;
        end
    end

    // shared add/subtract unit
    assign add_res = op_a + (sub ? ~op_b : op_b) + (SUM_W+1)'(sub);
    assign ge      = !add_res[SUM_W];
    assign rem_new = ge ? add_res[CNT_W-1:0] : rem_shift[CNT_W-1:0];

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.acc_clr)
        begin
            acc_next = '0;
        end
        else if (ctl.acc_add)
        begin
            acc_next = add_res[SUM_W-1:0];
        end
        else if (ctl.div_step)
        begin
            acc_next = {rem_new, acc_reg[QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            prod_reg <= prod_next;
            acc_reg  <= acc_next;
        end
    end

    assign quotient = acc_reg[QUO_W-1:0];

endmodule
`default_nettype wire

>>> rtl/hhwm_ctrl.sv
`default_nettype none
module hhwm_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic                       out_free,
    output logic                            busy,
    output logic                            load_out,
    output logic [hhwm_pkg::BIN_W-1:0]      rd_idx,
    output hhwm_pkg::alu_ctl_t              ctl
);
    import hhwm_pkg::*;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              pv_reg, pv_next;
    logic              issue;

    assign busy   = (state_reg != S_IDLE);
    assign rd_idx = step_reg[BIN_W-1:0];
    assign issue  = (step_reg < STEP_W'(BINS));

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        pv_next    = 1'b0;
        load_out   = 1'b0;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next  = S_MAC;
                    step_next   = '0;
                    ctl.acc_clr = 1'b1;
                end
            end
            S_MAC:
            begin
                // product registered in the cycle before its accumulate
                ctl.load_prod = issue;
                ctl.acc_add   = pv_reg;
                pv_next       = issue;
                if (issue)
                begin
                    step_next = step_reg + STEP_W'(1);
                end
                else
                begin
                    step_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(QUO_W - 1))
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            pv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            pv_reg    <= pv_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/height_histogram_weighted_mean.sv
// Samples and tone writes: one transaction per cycle while in_stall is low.
// A sample with last set holds in_stall high through the multiply-accumulate pass
// over the BINS bins, QUO_W restoring divide steps and one load, which waits while a
// stalled result is still held; the result shows on out_valid once that load is done.
// Reset (rst_n low, async) clears histogram, tone table, counts and out_valid.
`default_nettype none
module height_histogram_weighted_mean (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic                                 opcode,
    input  wire logic signed [hhwm_pkg::HEIGHT_W-1:0] height,
    input  wire logic                                 last,
    input  wire logic [hhwm_pkg::TIDX_W-1:0]          tone_index,
    input  wire logic [hhwm_pkg::TONE_W-1:0]          tone_weight,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [hhwm_pkg::QUO_W-1:0]                mean_freq,
    output logic [hhwm_pkg::PIX_W-1:0]                pixel_count,
    output logic                                      overflow
);
    import hhwm_pkg::*;

    logic             busy;
    logic             take;
    logic             sample_en;
    logic             tone_we;
    logic             start;
    logic             out_free;
    logic             load_out;
    logic [BIN_W-1:0] rd_idx;
    logic [QUO_W-1:0] quotient;
    hist_rd_t         rd;
    alu_ctl_t         ctl;

    logic             out_valid_reg, out_valid_next;
    logic [QUO_W-1:0] mean_reg, mean_next;
    logic [PIX_W-1:0] pix_reg, pix_next;
    logic             ovf_reg, ovf_next;

    assign in_stall  = busy;
    assign take      = in_valid && !in_stall;
    assign sample_en = take && (opcode == OP_SAMPLE);
    assign tone_we   = take && (opcode == OP_TONE);
    assign start     = sample_en && last;
    assign out_free  = !out_valid_reg || !out_stall;

    hhwm_hist u_hist (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_en   (sample_en),
        .height      (height),
        .tone_we     (tone_we),
        .tone_index  (tone_index),
        .tone_weight (tone_weight),
        .rd_idx      (rd_idx),
        .clear       (load_out),
        .rd          (rd)
    );

    hhwm_alu u_alu (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .bin_cnt  (rd.bin_cnt),
        .tone     (rd.tone),
        .divisor  (rd.frame_cnt),
        .quotient (quotient)
    );

    hhwm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .out_free (out_free),
        .busy     (busy),
        .load_out (load_out),
        .rd_idx   (rd_idx),
        .ctl      (ctl)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        mean_next      = mean_reg;
        pix_next       = pix_reg;
        ovf_next       = ovf_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            // empty frame reports zero
            mean_next      = (rd.frame_cnt == '0) ? '0 : quotient;
            pix_next       = PIX_W'(rd.frame_cnt);
            ovf_next       = rd.dropped;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            mean_reg      <= '0;
            pix_reg       <= '0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            mean_reg      <= mean_next;
            pix_reg       <= pix_next;
            ovf_reg       <= ovf_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign mean_freq   = mean_reg;
    assign pixel_count = pix_reg;
    assign overflow    = ovf_reg;

endmodule
`default_nettype wire

>>> rtl/hhwm_chk.sv
`default_nettype none
`include "height_histogram_weighted_mean_assert.svh"
module hhwm_chk (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 in_valid,
    input wire logic                                 in_stall,
    input wire logic                                 opcode,
    input wire logic                                 last,
    input wire logic                                 out_valid,
    input wire logic                                 out_stall,
    input wire logic [hhwm_pkg::QUO_W-1:0]           mean_freq,
    input wire logic [hhwm_pkg::PIX_W-1:0]           pixel_count,
    input wire logic                                 overflow
);
    import hhwm_pkg::*;

    logic [QUO_W+PIX_W:0] out_word;

    assign out_word = {mean_freq, pixel_count, overflow};

    // frame end starts the multiply/divide run
    `HHWM_ASSERT_NEXT(a_last_busy, in_valid && !in_stall && opcode == OP_SAMPLE && last, in_stall)
    // tone writes never stall the next transaction
    `HHWM_ASSERT_NEXT(a_tone_free, in_valid && !in_stall && opcode == OP_TONE, !in_stall)
    // dropped samples only once the frame is full
    `HHWM_ASSERT_NOW(a_ovf_full, out_valid && overflow, pixel_count == PIX_W'(MAX_PIXELS))
    `HHWM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

endmodule

bind height_histogram_weighted_mean hhwm_chk u_hhwm_chk (.*);
`default_nettype wire
